>>> rtl/core/gnbs_pkg.sv
package gnbs_pkg;

  // Bit store geometry.
  localparam int STORE_WORDS = 12;
  localparam int STORE_BITS  = STORE_WORDS * 32;
  localparam int WORD_W      = $clog2(STORE_WORDS);
  localparam int POS_W       = $clog2(STORE_BITS);
  localparam int SUM_W       = POS_W + 1;

  // Epoch tracking.
  localparam int PHASE_W         = 5;
  localparam int EPOCHS_PER_BIT  = 20;
  localparam int EDGE_CNT_W      = 4;
  localparam int THR_W           = 4;
  localparam logic [THR_W-1:0] THR_RESET = 4'd5;
  localparam int CORR_W          = 16;
  localparam int INTEG_W         = 21;

  // Navigation message layout, in bits from the start of a subframe.
  localparam logic [7:0] PREAMBLE     = 8'h8B;
  localparam logic [7:0] PREAMBLE_INV = 8'h74;
  localparam int SEARCH_BACK      = 360;
  localparam int SUBFRAME_LEN     = 300;
  localparam int TOW_FIELD_OFS    = 29;
  localparam int TOW2_FIELD_OFS   = SUBFRAME_LEN + TOW_FIELD_OFS;

  // Time of week.
  localparam int TOW_W    = 17;
  localparam int TOW_MS_W = 30;
  localparam logic [TOW_W:0]      TOW_PER_WEEK = 18'd100800;
  localparam logic [TOW_MS_W-1:0] MS_PER_TOW   = 30'd6000;
  localparam logic [TOW_MS_W-1:0] TOW_CORR_MS  = 30'((300 - 60) * 20);
  localparam logic [TOW_MS_W-1:0] WEEK_MS      = 30'(7 * 24 * 60 * 60 * 1000);

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic clear;    // mark found subframe processed
    logic wr_bit;   // a nav bit closes on this epoch
    logic bit_val;  // sign of the finished bit sum
    logic locked;   // bit phase lock after this epoch
  } gnbs_op_t;

endpackage

>>> rtl/core/gnbs_front.sv
module gnbs_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_command,
  input  logic signed [gnbs_pkg::CORR_W-1:0] in_correlation,
  input  logic [gnbs_pkg::THR_W-1:0]         lock_thr,
  input  logic                               q_ready,
  output logic                               q_push,
  output gnbs_pkg::gnbs_op_t                 q_op
);
  import gnbs_pkg::*;

  logic [PHASE_W-1:0]        ep_r, ep_nxt, ep_inc;
  logic [PHASE_W-1:0]        pr_r, pr_nxt;
  logic [EDGE_CNT_W-1:0]     emc_r, emc_nxt;
  logic signed [INTEG_W-1:0] bi_r, bi_nxt;
  logic                      integ_pos, corr_pos;

  assign in_ready = q_ready;
  assign q_push   = in_valid & q_ready;

  assign ep_inc    = (ep_r == PHASE_W'(EPOCHS_PER_BIT - 1)) ? '0 : ep_r + 1'b1;
  assign integ_pos = !bi_r[INTEG_W-1] && (bi_r != '0);
  assign corr_pos  = !in_correlation[CORR_W-1] && (in_correlation != '0);

  always_comb begin
    ep_nxt     = ep_r;
    pr_nxt     = pr_r;
    emc_nxt    = emc_r;
    bi_nxt     = bi_r;
    q_op.clear   = in_command;
    q_op.wr_bit  = 1'b0;
    q_op.bit_val = integ_pos;
    if (!in_command) begin
      ep_nxt = ep_inc;
      if (emc_r < lock_thr) begin
        // Still hunting for the bit edge: count sign flips on one phase.
        if (integ_pos != corr_pos) begin
          if (ep_inc == pr_r) begin
            if (emc_r != '1) begin
              emc_nxt = emc_r + 1'b1;
            end
          end else begin
            pr_nxt  = ep_inc;
            emc_nxt = EDGE_CNT_W'(1);
          end
        end
        bi_nxt = INTEG_W'(in_correlation);
      end else if (ep_inc != pr_r) begin
        bi_nxt = bi_r + INTEG_W'(in_correlation);
      end else begin
        q_op.wr_bit = 1'b1;
        bi_nxt      = '0;
      end
    end
    q_op.locked = (emc_nxt >= lock_thr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ep_r  <= '0;
      pr_r  <= '0;
      emc_r <= '0;
      bi_r  <= '0;
    end else if (q_push) begin
      ep_r  <= ep_nxt;
      pr_r  <= pr_nxt;
      emc_r <= emc_nxt;
      bi_r  <= bi_nxt;
    end
  end

endmodule

>>> rtl/core/gnbs_queue.sv
module gnbs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  gnbs_pkg::gnbs_op_t push_op,
  output logic               push_ready,
  input  logic               pop,
  output gnbs_pkg::gnbs_op_t pop_op,
  output logic               pop_valid
);
  import gnbs_pkg::*;

  gnbs_op_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     count_r, count_nxt;
  logic                do_push, do_pop;

  assign push_ready = (count_r != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_op     = slot_r[rd_ptr_r];
  assign do_push    = push & push_ready;
  assign do_pop     = pop & pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

>>> rtl/core/gnbs_back.sv
module gnbs_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  gnbs_pkg::gnbs_op_t               q_op,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_tow_found,
  output logic [gnbs_pkg::TOW_MS_W-1:0]    out_tow_ms,
  output logic                             out_bit_locked
);
  import gnbs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WR   = 3'd1;
  localparam logic [2:0] S_SA   = 3'd2;
  localparam logic [2:0] S_SB   = 3'd3;
  localparam logic [2:0] S_SC   = 3'd4;
  localparam logic [2:0] S_SD   = 3'd5;
  localparam logic [2:0] S_SE   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]            state_r, state_nxt;
  logic [POS_W-1:0]      wp_r, wp_nxt;
  logic [POS_W-1:0]      p_r, p_nxt;
  logic                  frame_set_r, frame_set_nxt;
  logic                  inv_r, inv_nxt;
  logic                  bit_val_r, bit_val_nxt;
  logic                  locked_r, locked_nxt;
  logic                  found_r, found_nxt;
  logic [TOW_W-1:0]      tow_r, tow_nxt;
  logic [TOW_MS_W-1:0]   prod_r, prod_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [TOW_MS_W-1:0]   out_ms_r, out_ms_nxt;
  logic                  out_locked_r, out_locked_nxt;
  logic                  out_free;

  // Bit store: word memory with two registered read ports and one write port.
  logic [31:0]           store_mem [STORE_WORDS];
  logic [STORE_WORDS-1:0] word_valid_r;
  logic [31:0]           rd_hi_r, rd_lo_r;
  logic [4:0]            rd_off_r;

  logic [POS_W-1:0]      rd_base;
  logic [SUM_W-1:0]      rd_step, rd_sum, rd_q;
  logic [POS_W-1:0]      rd_pos;
  logic [WORD_W-1:0]     rd_word, rd_word_next;

  logic                  mem_we;
  logic [WORD_W-1:0]     wr_word;
  logic [31:0]           wr_mask, wr_data;

  logic [63:0]           window;
  logic [7:0]            fld8;
  logic [17:0]           fld18;
  logic                  tow_flip;
  logic [TOW_W-1:0]      tow_raw;
  logic [TOW_W:0]        tow_inc;
  logic [SUM_W-1:0]      p_sum;

  assign out_free = !out_valid_r || out_ready;

  // Read address: a bit position plus a field offset, wrapped once.
  always_comb begin
    rd_base = p_r;
    rd_step = '0;
    case (state_r)
      S_SB:    rd_step = SUM_W'(SUBFRAME_LEN);
      S_SC:    rd_step = SUM_W'(TOW_FIELD_OFS);
      S_SD:    rd_step = SUM_W'(TOW2_FIELD_OFS);
      S_SA:    rd_step = '0;
      default: rd_base = wp_r;
    endcase
  end

  assign rd_sum       = {1'b0, rd_base} + rd_step;
  assign rd_q         = (rd_sum >= SUM_W'(STORE_BITS)) ? rd_sum - SUM_W'(STORE_BITS) : rd_sum;
  assign rd_pos       = rd_q[POS_W-1:0];
  assign rd_word      = rd_pos[POS_W-1:5];
  assign rd_word_next = (rd_word == WORD_W'(STORE_WORDS - 1)) ? '0 : rd_word + 1'b1;

  always_ff @(posedge clk) begin
    rd_hi_r  <= word_valid_r[rd_word] ? store_mem[rd_word] : '0;
    rd_lo_r  <= word_valid_r[rd_word_next] ? store_mem[rd_word_next] : '0;
    rd_off_r <= rd_pos[4:0];
  end

  // Bit write: read-modify-write of the word read in the idle cycle.
  assign mem_we  = (state_r == S_WR);
  assign wr_word = wp_r[POS_W-1:5];
  assign wr_mask = 32'h8000_0000 >> wp_r[4:0];
  assign wr_data = bit_val_r ? (rd_hi_r | wr_mask) : (rd_hi_r & ~wr_mask);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[wr_word] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_valid_r <= '0;
    end else if (mem_we) begin
      word_valid_r[wr_word] <= 1'b1;
    end
  end

  // Field extraction, MSB first, from the two words read last cycle.
  assign window   = {rd_hi_r, rd_lo_r} << rd_off_r;
  assign fld8     = window[63:56];
  assign fld18    = window[63:46];
  assign tow_flip = inv_r ^ (fld18[17] ^ inv_r);
  assign tow_raw  = fld18[16:0] ^ {TOW_W{tow_flip}};
  assign tow_inc  = {1'b0, tow_raw} + 1'b1;

  assign p_sum = {1'b0, wp_nxt} + SUM_W'(STORE_BITS - SEARCH_BACK);

  always_comb begin
    state_nxt      = state_r;
    wp_nxt         = wp_r;
    p_nxt          = p_r;
    frame_set_nxt  = frame_set_r;
    inv_nxt        = inv_r;
    bit_val_nxt    = bit_val_r;
    locked_nxt     = locked_r;
    found_nxt      = found_r;
    tow_nxt        = tow_r;
    prod_nxt       = prod_r;
    q_pop          = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_found_nxt  = out_found_r;
    out_ms_nxt     = out_ms_r;
    out_locked_nxt = out_locked_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_op.wr_bit) begin
            q_pop       = 1'b1;
            bit_val_nxt = q_op.bit_val;
            locked_nxt  = q_op.locked;
            state_nxt   = S_WR;
          end else if (out_free) begin
            q_pop          = 1'b1;
            if (q_op.clear) begin
              frame_set_nxt = 1'b0;
            end
            out_valid_nxt  = 1'b1;
            out_found_nxt  = 1'b0;
            out_ms_nxt     = '0;
            out_locked_nxt = q_op.locked;
          end
        end
      end
      S_WR: begin
        wp_nxt    = (wp_r == POS_W'(STORE_BITS - 1)) ? '0 : wp_r + 1'b1;
        p_nxt     = (p_sum >= SUM_W'(STORE_BITS)) ? POS_W'(p_sum - SUM_W'(STORE_BITS))
                                                  : POS_W'(p_sum);
        found_nxt = 1'b0;
        state_nxt = frame_set_r ? S_DONE : S_SA;
      end
      S_SA: begin
        state_nxt = S_SB;
      end
      S_SB: begin
        if (fld8 == PREAMBLE) begin
          frame_set_nxt = 1'b1;
          inv_nxt       = 1'b0;
          state_nxt     = S_SC;
        end else if (fld8 == PREAMBLE_INV) begin
          frame_set_nxt = 1'b1;
          inv_nxt       = 1'b1;
          state_nxt     = S_SC;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SC: begin
        state_nxt = ((fld8 ^ {8{inv_r}}) == PREAMBLE) ? S_SD : S_DONE;
      end
      S_SD: begin
        tow_nxt   = (tow_inc >= TOW_PER_WEEK) ? '0 : tow_inc[TOW_W-1:0];
        state_nxt = S_SE;
      end
      S_SE: begin
        found_nxt = (tow_raw == tow_r);
        prod_nxt  = TOW_MS_W'(tow_r) * MS_PER_TOW;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = found_r;
          if (!found_r) begin
            out_ms_nxt = '0;
          end else if (tow_r != '0) begin
            out_ms_nxt = prod_r - TOW_CORR_MS;
          end else begin
            out_ms_nxt = WEEK_MS - TOW_CORR_MS;
          end
          out_locked_nxt = locked_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      frame_set_r <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      frame_set_r <= frame_set_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r          <= p_nxt;
    inv_r        <= inv_nxt;
    bit_val_r    <= bit_val_nxt;
    locked_r     <= locked_nxt;
    tow_r        <= tow_nxt;
    prod_r       <= prod_nxt;
    out_found_r  <= out_found_nxt;
    out_ms_r     <= out_ms_nxt;
    out_locked_r <= out_locked_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_tow_found  = out_found_r;
  assign out_tow_ms     = out_ms_r;
  assign out_bit_locked = out_locked_r;

endmodule

>>> rtl/core/gps_nav_bit_sync_tow_decoder.sv
// GPS L1 C/A navigation bit synchronizer and time-of-week decoder. Each input
// transfer carries either one 1 ms prompt correlation (command 0) or a request
// to release the held subframe (command 1), and every input transfer produces
// exactly one output transfer, in order. Until as many sign edges as the lock
// threshold have fallen on the same epoch phase the block only hunts for the
// bit edge; after that it sums the correlations between bit edges into each
// nav bit, stores the sign in a 384-bit circular store, and searches 360 bits
// back for the 0x8B preamble (0x74 when inverted) confirmed by a second one 300
// bits later with an incrementing truncated time of week. A confirmed find
// reports the time of week in ms; any preamble find holds the frame until a
// release command, and the search stays stopped while a frame is held. A front
// stage classifies one input transfer per cycle while the queue has room and
// feeds a four-entry queue; the back stage answers an item that closes no bit
// from its idle state, passes a closed bit through its write state and, while
// no frame is held, through search states that follow the word reads on the
// bit store's two read ports, then gives the result from its done state. The
// threshold register is written through cfg_wr_en and cfg_wr_data and should
// only change while no transfer is in flight.
module gps_nav_bit_sync_tow_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [gnbs_pkg::THR_W-1:0]         cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_command,
  input  logic signed [gnbs_pkg::CORR_W-1:0] in_correlation,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_tow_found,
  output logic [gnbs_pkg::TOW_MS_W-1:0]      out_tow_ms,
  output logic                               out_bit_locked
);
  import gnbs_pkg::*;

  // Lock threshold register.
  logic [THR_W-1:0] lock_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      lock_thr_r <= cfg_wr_data;
    end
  end

  // Front to queue.
  logic     push, push_ready;
  gnbs_op_t push_op;

  // Queue to back.
  logic     pop, pop_valid;
  gnbs_op_t pop_op;

  // The front tracks epoch phase, edge lock and the bit sum; it only needs
  // room in the queue to take a transfer.
  gnbs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_correlation (in_correlation),
    .lock_thr       (lock_thr_r),
    .q_ready        (push_ready),
    .q_push         (push),
    .q_op           (push_op)
  );

  gnbs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_op    (push_op),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_op     (pop_op),
    .pop_valid  (pop_valid)
  );

  // The back owns the bit store, the write position and the held frame,
  // and drives the registered output.
  gnbs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (pop_valid),
    .q_op           (pop_op),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tow_found  (out_tow_found),
    .out_tow_ms     (out_tow_ms),
    .out_bit_locked (out_bit_locked)
  );

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
  import gnbs_pkg::*;

  // Input command codes carried on in_command.
  localparam logic CMD_EPOCH   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic signed [CORR_W-1:0] CORR_MAX = 16'sh7FFF;
  localparam logic signed [CORR_W-1:0] CORR_MIN = 16'sh8000;

  // Navigation message layout and time of week scaling, kept apart from the
  // package so that the prediction does not lean on the design's own numbers.
  localparam int          EPOCHS_PER_NAV_BIT = 20;
  localparam int          LOOKBACK_BITS      = 360;
  localparam int          SF_BITS            = 300;
  localparam int          PARITY_D_OFS       = 29;
  localparam int          TOW_OFS            = 30;
  localparam int          TOW_BITS           = 17;
  localparam int unsigned WEEK_TOWS          = 100800;
  localparam int unsigned MS_PER_TOW_COUNT   = 6000;
  localparam int unsigned TOW_LEAD_MS        = 4800;
  localparam int unsigned WEEK_MS_TOTAL      = 604800000;
  localparam logic [7:0]  SYNC_WORD          = 8'h8B;
  localparam logic [7:0]  SYNC_WORD_INV      = 8'h74;
  localparam int          LEAD_IN_BITS       = 40;

  // Cycles waited after the last result so that the block is quiet.
  localparam int DRAIN_CYCLES     = 16;
  localparam int LONG_HOLD_CYCLES = 300;
  // No correct run goes this long without a single transfer on either side.
  localparam int WATCHDOG_LIMIT   = 5000;

  typedef struct packed {
    logic                found;
    logic [TOW_MS_W-1:0] ms;
    logic                locked;
  } tow_result_t;

  // Bit-accurate model of the decoder plus the queue of results it owes.
  class tow_scoreboard;
    logic [THR_W-1:0] threshold;
    int unsigned      phase;
    int unsigned      phase_ref;
    int unsigned      edge_count;
    int unsigned      wr_pos;
    int               integ_sum;
    int               frame_offset;
    bit               nav_bits[STORE_BITS];
    tow_result_t      expected_q[$];
    int               error_count;

    function new();
      threshold    = THR_RESET;
      phase        = 0;
      phase_ref    = 0;
      edge_count   = 0;
      wr_pos       = 0;
      integ_sum    = 0;
      frame_offset = 0;
      error_count  = 0;
      foreach (nav_bits[i]) nav_bits[i] = 1'b0;
    endfunction

    function void flag(string what);
      error_count++;
      if (error_count <= 10) $display("%s", what);
    endfunction

    function bit held();
      return frame_offset != 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Reads n stored bits, oldest first, wrapping around the store.
    function logic [TOW_BITS-1:0] nav_field(int unsigned pos, int n, bit inv);
      logic [TOW_BITS-1:0] v;
      v = '0;
      for (int i = 0; i < n; i++)
        v = {v[TOW_BITS-2:0], nav_bits[(pos + i) % STORE_BITS] ^ inv};
      return v;
    endfunction

    function void frame_search(output bit found, output logic [TOW_MS_W-1:0] ms);
      int unsigned start;
      int unsigned tow_a;
      int unsigned tow_b;
      logic [7:0]  sync;
      bit          inv;
      bit          d;
      found = 1'b0;
      ms    = '0;
      start = (wr_pos + STORE_BITS - LOOKBACK_BITS) % STORE_BITS;
      sync  = 8'(nav_field(start, 8, 1'b0));
      if (sync == SYNC_WORD) begin
        frame_offset = int'(start) + 1;
      end else if (sync == SYNC_WORD_INV) begin
        frame_offset = -(int'(start) + 1);
      end else begin
        return;
      end
      inv = frame_offset < 0;
      // A lone preamble keeps the frame held even when it is not confirmed.
      if (8'(nav_field(start + SF_BITS, 8, inv)) != SYNC_WORD) return;
      d     = nav_bits[(start + PARITY_D_OFS) % STORE_BITS] ^ inv;
      tow_a = nav_field(start + TOW_OFS, TOW_BITS, inv ^ d) + 1;
      if (tow_a >= WEEK_TOWS) tow_a = 0;
      d     = nav_bits[(start + SF_BITS + PARITY_D_OFS) % STORE_BITS] ^ inv;
      tow_b = nav_field(start + SF_BITS + TOW_OFS, TOW_BITS, inv ^ d);
      if (tow_a != tow_b) return;
      found = 1'b1;
      if (tow_a != 0) begin
        ms = TOW_MS_W'(tow_a * MS_PER_TOW_COUNT - TOW_LEAD_MS);
      end else begin
        // The count wrapped past the end of the week.
        ms = TOW_MS_W'(WEEK_MS_TOTAL - TOW_LEAD_MS);
      end
    endfunction

    // Advances the model by one accepted input transfer.
    function void predict_epoch(logic cmd, logic signed [CORR_W-1:0] corr);
      tow_result_t         want;
      int                  c;
      bit                  found;
      logic [TOW_MS_W-1:0] ms;
      found = 1'b0;
      ms    = '0;
      if (cmd == CMD_RELEASE) begin
        frame_offset = 0;
      end else begin
        c     = corr;
        phase = (phase + 1) % EPOCHS_PER_NAV_BIT;
        if (edge_count < threshold) begin
          if ((integ_sum > 0) != (c > 0)) begin
            if (phase == phase_ref) begin
              if (edge_count < 15) edge_count++;
            end else begin
              phase_ref  = phase;
              edge_count = 1;
            end
          end
          integ_sum = c;
        end else if (phase != phase_ref) begin
          integ_sum += c;
        end else begin
          nav_bits[wr_pos] = integ_sum > 0;
          integ_sum = 0;
          wr_pos++;
          if (wr_pos >= STORE_BITS) wr_pos = 0;
          if (frame_offset == 0) frame_search(found, ms);
        end
      end
      want.found  = found;
      want.ms     = found ? ms : '0;
      want.locked = edge_count >= threshold;
      expected_q.push_back(want);
    endfunction

    function void check_tow_result(logic found, logic [TOW_MS_W-1:0] ms, logic locked);
      tow_result_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("result with nothing pending: found=%0b ms=%0d locked=%0b",
                       found, ms, locked));
        return;
      end
      want = expected_q.pop_front();
      if (found !== want.found || ms !== want.ms || locked !== want.locked)
        flag($sformatf("mismatch: expected found=%0b ms=%0d locked=%0b, got found=%0b ms=%0d locked=%0b",
                       want.found, want.ms, want.locked, found, ms, locked));
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [THR_W-1:0]           cfg_wr_data;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_command;
  logic signed [CORR_W-1:0]   in_correlation;
  logic                       out_valid;
  logic                       out_ready;
  logic                       out_tow_found;
  logic [TOW_MS_W-1:0]        out_tow_ms;
  logic                       out_bit_locked;

  tow_scoreboard sb = new();

  // Percentages of cycles in which each side holds back; the main sequence
  // changes them between phases.
  int send_idle_pct = 13;
  int recv_idle_pct = 68;
  // The main sequence bumps hold_requests to ask the receiver for one long
  // hold-off; the receiver counts the ones it has served.
  int hold_requests = 0;
  int holds_served  = 0;
  int quiet_cycles  = 0;

  gps_nav_bit_sync_tow_decoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_correlation (in_correlation),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tow_found  (out_tow_found),
    .out_tow_ms     (out_tow_ms),
    .out_bit_locked (out_bit_locked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offers one item and returns at the edge where its transfer happens. The
  // valid line is left high so that a following item can go out back to back;
  // whoever comes next either lowers it or replaces the payload.
  task automatic send_item(input logic cmd, input logic signed [CORR_W-1:0] corr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_correlation <= corr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.predict_epoch(cmd, corr);
  endtask

  // Stops offering and waits until every result owed has come out, then lets
  // the back stage settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The threshold only changes while nothing is in flight.
  task automatic write_threshold(input logic [THR_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.threshold = v;
  endtask

  // Sends the twenty epochs of one nav bit. Every sample carries the sign of
  // the bit, so the bit edge falls on one epoch phase; noisy mode now and then
  // swaps in a wild sample. While a frame is held, a release command follows
  // some epochs, as the tracking loop would send once it has read the frame.
  task automatic send_nav_bit(input bit b, input bit noisy);
    logic signed [CORR_W-1:0] s;
    repeat (EPOCHS_PER_NAV_BIT) begin
      if (b) begin
        s = 16'($urandom_range(32767, 1));
      end else begin
        s = 16'(-int'($urandom_range(32768, 0)));
      end
      if ($urandom_range(15) == 0) s = b ? CORR_MAX : CORR_MIN;
      if (noisy && $urandom_range(63) == 0) s = 16'($urandom);
      send_item(CMD_EPOCH, s);
      if (sb.held() && $urandom_range(29) == 0) send_item(CMD_RELEASE, 16'($urandom));
    end
  endtask

  // Sends an alternating lead-in for bit phase lock, then a run of subframes
  // with a preamble, a random D30 bit and a time of week count that steps by
  // one per subframe, and a short tail so the last pair gets searched.
  task automatic send_nav_stream(input bit inverted, input int unsigned first_tow,
                                 input int subframes, input bit noisy);
    bit          sf[SF_BITS];
    int unsigned tow;
    bit          d;
    for (int i = 0; i < LEAD_IN_BITS; i++) send_nav_bit(i[0], 1'b0);
    tow = first_tow;
    for (int k = 0; k < subframes; k++) begin
      foreach (sf[i]) sf[i] = $urandom_range(1);
      for (int i = 0; i < 8; i++) sf[i] = SYNC_WORD[7-i];
      d = $urandom_range(1);
      sf[PARITY_D_OFS] = d;
      // The time of week field goes out complemented when D30 is set.
      for (int i = 0; i < TOW_BITS; i++) sf[TOW_OFS+i] = tow[TOW_BITS-1-i] ^ d;
      foreach (sf[i]) send_nav_bit(sf[i] ^ inverted, noisy);
      tow = (tow + 1 >= WEEK_TOWS) ? 0 : tow + 1;
    end
    repeat (2) send_nav_bit($urandom_range(1), noisy);
  endtask

  // Unstructured traffic: random commands and correlations, biased toward
  // the extremes and the values around zero.
  task automatic send_noise_item();
    logic signed [CORR_W-1:0] s;
    case ($urandom_range(7))
      0: begin
        s = CORR_MAX;
      end
      1: begin
        s = CORR_MIN;
      end
      2: begin
        s = 16'(int'($urandom_range(2)) - 1);
      end
      default: begin
        s = 16'($urandom);
      end
    endcase
    send_item(($urandom_range(7) == 0) ? CMD_RELEASE : CMD_EPOCH, s);
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    in_valid       <= 1'b0;
    in_command     <= CMD_EPOCH;
    in_correlation <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items at the reset threshold: a release with no frame held
    // and correlations at both ends of the range and around zero.
    send_item(CMD_RELEASE, CORR_MAX);
    send_item(CMD_EPOCH, CORR_MAX);
    send_item(CMD_EPOCH, CORR_MIN);
    send_item(CMD_EPOCH, 16'sd0);
    send_item(CMD_EPOCH, -16'sd1);
    send_item(CMD_EPOCH, 16'sd1);

    // A threshold of zero locks at once; alternating extremes, with a release in
    // the middle, then feed the bit sum.
    write_threshold(4'd0);
    for (int i = 0; i < 20; i++) begin
      if (i == 10) begin
        send_item(CMD_RELEASE, CORR_MIN);
      end else begin
        send_item(CMD_EPOCH, i[0] ? CORR_MIN : CORR_MAX);
      end
    end

    // Upright stream at the reset threshold with a random time of week.
    write_threshold(THR_RESET);
    send_nav_stream(1'b0, $urandom_range(WEEK_TOWS - 3, 0), 3, 1'b1);

    // Inverted stream that runs across the end of the week. Raising the
    // threshold to its top value sends tracking back to the edge search.
    send_idle_pct = 68;
    recv_idle_pct = 13;
    write_threshold(4'd15);
    send_nav_stream(1'b1, WEEK_TOWS - 2, 3, 1'b1);

    // Clean stream whose first count lies beyond a week, then one step past
    // zero, at the lowest nonzero threshold with both sides running freely.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_threshold(4'd1);
    send_nav_stream(1'b0, (1 << TOW_BITS) - 2, 3, 1'b0);

    // Random traffic, opened by a long receiver hold-off that backs the
    // block up until it refuses input.
    hold_requests++;
    repeat (1000) send_noise_item();
    write_threshold(4'($urandom_range(15, 0)));
    repeat (1000) send_noise_item();

    drain();
    if (sb.error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Receiver: random back-pressure at the current rate, or one long hold-off
  // when the main sequence asks for it.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        out_ready <= 1'b0;
        for (int n = 1; n < LONG_HOLD_CYCLES; n++) @(posedge clk);
        holds_served++;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Every output transfer is checked against the oldest outstanding result.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_tow_result(out_tow_found, out_tow_ms, out_bit_locked);
  end

  // A run in which neither side moves anything for too long has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

endmodule

>>> sim.f
rtl/core/gnbs_pkg.sv
rtl/core/gnbs_front.sv
rtl/core/gnbs_queue.sv
rtl/core/gnbs_back.sv
rtl/core/gps_nav_bit_sync_tow_decoder.sv
test/tb.sv
